### src/drcm_pkg.sv
`default_nettype none

package drcm_pkg;

    // Word layout of the readout stream
    localparam int unsigned WORD_W      = 16;
    localparam int unsigned VALUE_W     = 12;
    localparam int unsigned SLOT_W      = 5;
    localparam int unsigned CRATE_W     = 8;
    localparam int unsigned CHAN_W      = 5;
    localparam int unsigned COUNT_W     = 6;
    localparam int unsigned WALL_W      = 5;
    localparam int unsigned KIND_W      = 2;

    localparam int unsigned SLOT_LSB    = 11;
    localparam int unsigned COUNT_LSB   = 8;

    // Mapping constants
    localparam int unsigned MAX_CHANNELS       = 32;
    localparam int unsigned SECOND_WALL_OFFSET = 9;
    localparam int unsigned TAG_WORD_COUNT     = 2;

    localparam logic [CRATE_W-1:0] CRATE_CHARGE     = 8'd0;
    localparam logic [CRATE_W-1:0] CRATE_TIME_LEFT  = 8'd1;
    localparam logic [CRATE_W-1:0] CRATE_TIME_RIGHT = 8'd2;

    localparam logic [SLOT_W-1:0] SLOT_TIME_A    = 5'd3;
    localparam logic [SLOT_W-1:0] SLOT_TIME_B    = 5'd6;
    localparam logic [SLOT_W-1:0] SLOT_TIME_C    = 5'd9;
    localparam logic [SLOT_W-1:0] SLOT_TIME_D    = 5'd12;
    localparam logic [SLOT_W-1:0] SLOT_TIME_END  = 5'd15;
    localparam logic [SLOT_W-1:0] SLOT_CHARGE_LO = 5'd3;
    localparam logic [SLOT_W-1:0] SLOT_CHARGE_HI = 5'd11;

    localparam logic [WALL_W-1:0] WALL_TIME_END  = 5'd8;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_TAG   = 3'd1,
        PH_HDR_A = 3'd2,
        PH_HDR_B = 3'd3,
        PH_CH_A  = 3'd4,
        PH_CH_B  = 3'd5,
        PH_TRL_A = 3'd6,
        PH_TRL_B = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CRATE = 2'd1,
        ST_SLOT  = 2'd2,
        ST_COUNT = 2'd3
    } status_t;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic              first_word;
        logic [KIND_W-1:0] func;
    } in_item_t;

    typedef struct packed {
        logic [WALL_W-1:0]  wall_index;
        logic [CHAN_W-1:0]  bar_index;
        logic               side;
        logic [VALUE_W-1:0] sample_value;
        logic [1:0]         status;
    } out_item_t;

    // One classified channel pair (or count error) handed to the back end
    typedef struct packed {
        status_t            status;
        logic               timing;
        logic               second;
        logic               side;
        logic [SLOT_W-1:0]  slot;
        logic [CHAN_W-1:0]  channel;
        logic [VALUE_W-1:0] value;
    } job_t;

endpackage

`default_nettype wire

### src/digitizer_readout_channel_mapper.sv
// Channel  Direction  Handshake                   Payload
// item     in         item_valid / item_ready     in_item_t  (data_word, first_word, func)
// result   out        result_valid / result_ready out_item_t (wall, bar, side, value, status)
//
// One readout word per cycle is taken when the queue has room; the parser
// decides every word in the cycle of its transfer.
// A result passes from its word into the queue and then into the output
// register before it appears.
// Reset (rst_n, asynchronous, active low) clears the parse phase, the counters,
// the queue pointers and the output valid; no clearing pass is needed.
// A stalled result side fills the queue and then holds item_ready low.
`default_nettype none

module digitizer_readout_channel_mapper #(
    parameter int unsigned QUEUE_DEPTH = drcm_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_ready,
    input  drcm_pkg::in_item_t  item,
    output logic                result_valid,
    input  wire logic           result_ready,
    output drcm_pkg::out_item_t result
);
    import drcm_pkg::*;

    logic  item_fire;
    logic  push;
    job_t  push_job;
    job_t  head_job;
    logic  pop;
    logic  full;
    logic  empty;

    // Accept a word whenever the queue can take the job it might produce
    assign item_ready = !full;
    assign item_fire  = item_valid && item_ready;

    // Front: parse the subpacket structure and classify each channel pair
    drcm_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (item_fire),
        .item  (item),
        .push  (push),
        .job   (push_job)
    );

    // Short queue: lets the parser advance while a result waits at the output
    drcm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (full),
        .empty    (empty)
    );

    // Back: map to wall, bar and side, and hold the result for transfer
    drcm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_job     (head_job),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

### src/drcm_front.sv
`default_nettype none

module drcm_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  drcm_pkg::in_item_t     item,
    output logic                   push,
    output drcm_pkg::job_t         job
);
    import drcm_pkg::*;

    phase_t              phase_reg,    phase_next;
    logic [WORD_W-1:0]   length_reg,   length_next;
    logic [WORD_W-1:0]   consumed_reg, consumed_next;
    logic [SLOT_W-1:0]   slot_reg,     slot_next;
    logic [CRATE_W-1:0]  crate_reg,    crate_next;
    logic [COUNT_W-1:0]  left_reg,     left_next;
    logic [CHAN_W-1:0]   chan_reg,     chan_next;
    logic [KIND_W-1:0]   kind_reg,     kind_next;

    logic [WORD_W-1:0]   consumed_inc;
    logic [COUNT_W-1:0]  count_field;
    logic [COUNT_W-1:0]  left_dec;
    logic                timing;
    status_t             map_status;
    logic                slot_time_ok;
    logic                slot_charge_ok;

    assign consumed_inc = consumed_reg + WORD_W'(1);
    assign count_field  = item.data_word[COUNT_LSB +: COUNT_W];
    assign left_dec     = left_reg - COUNT_W'(1);
    assign timing       = ~kind_reg[1];

    assign slot_time_ok = (slot_reg == SLOT_TIME_A) || (slot_reg == SLOT_TIME_B) ||
                          (slot_reg == SLOT_TIME_C) || (slot_reg == SLOT_TIME_D) ||
                          (slot_reg == SLOT_TIME_END);
    assign slot_charge_ok = (slot_reg >= SLOT_CHARGE_LO) && (slot_reg <= SLOT_CHARGE_HI);

    // Classify the held module against the rule of this subpacket kind
    always_comb
    begin
        priority if (timing && crate_reg != CRATE_TIME_LEFT && crate_reg != CRATE_TIME_RIGHT)
            map_status = ST_CRATE;
        else if (timing && !slot_time_ok)
            map_status = ST_SLOT;
        else if (!timing && crate_reg != CRATE_CHARGE)
            map_status = ST_CRATE;
        else if (!timing && !slot_charge_ok)
            map_status = ST_SLOT;
        else
            map_status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            length_reg   <= '0;
            consumed_reg <= '0;
            slot_reg     <= '0;
            crate_reg    <= '0;
            left_reg     <= '0;
            chan_reg     <= '0;
            kind_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            length_reg   <= length_next;
            consumed_reg <= consumed_next;
            slot_reg     <= slot_next;
            crate_reg    <= crate_next;
            left_reg     <= left_next;
            chan_reg     <= chan_next;
            kind_reg     <= kind_next;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        length_next   = length_reg;
        consumed_next = consumed_reg;
        slot_next     = slot_reg;
        crate_next    = crate_reg;
        left_next     = left_reg;
        chan_next     = chan_reg;
        kind_next     = kind_reg;
        push          = 1'b0;
        job           = '0;

        if (fire)
        begin
            if (item.first_word)
            begin
                length_next   = item.data_word - WORD_W'(TAG_WORD_COUNT);
                consumed_next = '0;
                kind_next     = item.func;
                phase_next    = PH_TAG;
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        // drop stray word
                    end
                    PH_TAG:
                    begin
                        consumed_next = WORD_W'(TAG_WORD_COUNT);
                        phase_next    = (WORD_W'(TAG_WORD_COUNT) < length_reg) ?
                                        PH_HDR_A : PH_IDLE;
                    end
                    PH_HDR_A:
                    begin
                        slot_next     = item.data_word[SLOT_LSB +: SLOT_W];
                        crate_next    = item.data_word[CRATE_W-1:0];
                        consumed_next = consumed_inc;
                        phase_next    = PH_HDR_B;
                    end
                    PH_HDR_B:
                    begin
                        consumed_next = consumed_inc;
                        if (count_field > COUNT_W'(MAX_CHANNELS))
                        begin
                            phase_next = PH_IDLE;
                            push       = 1'b1;
                            job.status = ST_COUNT;
                        end
                        else
                        begin
                            left_next  = count_field;
                            phase_next = (count_field == '0) ? PH_TRL_A : PH_CH_A;
                        end
                    end
                    PH_CH_A:
                    begin
                        chan_next     = item.data_word[CHAN_W-1:0];
                        consumed_next = consumed_inc;
                        phase_next    = PH_CH_B;
                    end
                    PH_CH_B:
                    begin
                        consumed_next = consumed_inc;
                        push          = 1'b1;
                        job.status    = map_status;
                        job.timing    = timing;
                        job.second    = kind_reg[0];
                        job.side      = timing ? (crate_reg == CRATE_TIME_RIGHT)
                                               : ~chan_reg[CHAN_W-1];
                        job.slot      = slot_reg;
                        job.channel   = chan_reg;
                        job.value     = item.data_word[VALUE_W-1:0];
                        if (timing && map_status != ST_OK)
                            phase_next = PH_IDLE;
                        else
                        begin
                            left_next  = left_dec;
                            phase_next = (left_dec == '0) ? PH_TRL_A : PH_CH_A;
                        end
                    end
                    PH_TRL_A:
                    begin
                        consumed_next = consumed_inc;
                        phase_next    = PH_TRL_B;
                    end
                    PH_TRL_B:
                    begin
                        consumed_next = consumed_inc;
                        phase_next    = (consumed_inc < length_reg) ? PH_HDR_A : PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Results come only from a channel value word or a channel count word
    a_push_phase: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (phase_reg == PH_HDR_B || phase_reg == PH_CH_B) && !item.first_word)
        else $error("job pushed outside count or value phase");

    // A timing mapping error ends the subpacket
    a_timing_abort: assert property (@(posedge clk) disable iff (!rst_n)
        (push && job.timing && job.status != ST_OK) |=> phase_reg == PH_IDLE)
        else $error("timing error did not abort subpacket");

endmodule

`default_nettype wire

### src/drcm_queue.sv
`default_nettype none

module drcm_queue #(
    parameter int unsigned DEPTH = drcm_pkg::QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  drcm_pkg::job_t    push_job,
    input  wire logic         pop,
    output drcm_pkg::job_t    head_job,
    output logic              full,
    output logic              empty
);
    import drcm_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count lost a push");

endmodule

`default_nettype wire

### src/drcm_back.sv
`default_nettype none

module drcm_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  drcm_pkg::job_t      head_job,
    input  wire logic           empty,
    output logic                pop,
    output logic                result_valid,
    input  wire logic           result_ready,
    output drcm_pkg::out_item_t result
);
    import drcm_pkg::*;

    logic              valid_reg, valid_next;
    out_item_t         result_reg, result_next;
    logic [WALL_W-1:0] wall_offset;
    logic [WALL_W-1:0] time_base;
    logic [WALL_W-1:0] wall;
    logic [CHAN_W-1:0] bar;
    logic              upper;

    assign upper       = head_job.channel[CHAN_W-1];
    assign wall_offset = head_job.second ? WALL_W'(SECOND_WALL_OFFSET) : '0;

    always_comb
    begin
        unique case (head_job.slot)
            SLOT_TIME_B: time_base = 5'd2;
            SLOT_TIME_C: time_base = 5'd4;
            SLOT_TIME_D: time_base = 5'd6;
            default:     time_base = 5'd0;
        endcase
    end

    // Wall and bar from the job; bar is the low four channel bits, except in the end slot
    always_comb
    begin
        if (head_job.timing)
        begin
            if (head_job.slot == SLOT_TIME_END)
            begin
                wall = WALL_TIME_END + wall_offset;
                bar  = head_job.channel;
            end
            else
            begin
                wall = time_base + WALL_W'(upper) + wall_offset;
                bar  = {1'b0, head_job.channel[CHAN_W-2:0]};
            end
        end
        else
        begin
            wall = head_job.slot - SLOT_CHARGE_LO + wall_offset;
            bar  = {1'b0, head_job.channel[CHAN_W-2:0]};
        end
    end

    assign pop = !empty && (!valid_reg || result_ready);

    always_comb
    begin
        valid_next  = valid_reg;
        result_next = result_reg;
        if (result_ready)
            valid_next = 1'b0;
        if (pop)
        begin
            valid_next         = 1'b1;
            result_next.status = head_job.status;
            if (head_job.status == ST_OK)
            begin
                result_next.wall_index   = wall;
                result_next.bar_index    = bar;
                result_next.side         = head_job.side;
                result_next.sample_value = head_job.value;
            end
            else
            begin
                result_next.wall_index   = '0;
                result_next.bar_index    = '0;
                result_next.side         = 1'b0;
                result_next.sample_value = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

    a_error_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && result_reg.status != ST_OK) |->
            (result_reg.wall_index == '0 && result_reg.bar_index == '0 &&
             !result_reg.side && result_reg.sample_value == '0))
        else $error("error result carries mapping fields");

    a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> valid_reg)
        else $error("popped job did not reach output register");

endmodule

`default_nettype wire
